/* rtl/cme_pkg.sv */
`timescale 1ns / 1ps

package cme_pkg;

   localparam int QUIET_MODULES = 10;
   localparam int QueueDepth    = 4;
   localparam int QueuePtrW     = $clog2(QueueDepth);
   localparam int QueueCntW     = $clog2(QueueDepth + 1);

   // the quiet zone width lives in a 4-bit field
   localparam logic [3:0] QuietWidth = 4'(QUIET_MODULES);

   localparam logic [4:0] SymA     = 5'd16;
   localparam logic [3:0] GapWidth = 4'd1;

   // one chunk slot of the fixed sequence, one bit each
   typedef enum logic [2:0] {
      SLOT_LEAD_QUIET = 3'd0,
      SLOT_START_SYM  = 3'd1,
      SLOT_START_GAP  = 3'd2,
      SLOT_DATA_SYM   = 3'd3,
      SLOT_DATA_GAP   = 3'd4,
      SLOT_STOP_SYM   = 3'd5,
      SLOT_END_QUIET  = 3'd6
   } slot_type;

   localparam int NumSlots = 7;

   typedef struct packed {
      logic       do_start;
      logic       do_data;
      logic       do_end;
      logic [4:0] edge_idx;   // start and stop letter symbol
      logic [3:0] data_idx;
   } plan_type;

   typedef struct packed {
      logic     valid;
      plan_type plan;
   } qport_type;

   function automatic logic [12:0] sym_bits(input logic [4:0] idx);
      logic [12:0] bits;
      case (idx)
         5'd0:    bits = 13'h0547;
         5'd1:    bits = 13'h0571;
         5'd2:    bits = 13'h0517;
         5'd3:    bits = 13'h0715;
         5'd4:    bits = 13'h05D1;
         5'd5:    bits = 13'h0751;
         5'd6:    bits = 13'h0457;
         5'd7:    bits = 13'h045D;
         5'd8:    bits = 13'h0475;
         5'd9:    bits = 13'h0745;
         5'd10:   bits = 13'h051D;
         5'd11:   bits = 13'h05C5;
         5'd12:   bits = 13'h1DDD;
         5'd13:   bits = 13'h1DD7;
         5'd14:   bits = 13'h1D77;
         5'd15:   bits = 13'h1777;
         5'd16:   bits = 13'h1711;
         5'd17:   bits = 13'h1117;
         5'd18:   bits = 13'h1447;
         5'd19:   bits = 13'h1471;
         default: bits = 13'h0000;
      endcase
      return bits;
   endfunction

   function automatic logic [3:0] sym_width(input logic [4:0] idx);
      return (idx >= 5'd12) ? 4'd13 : 4'd11;
   endfunction

endpackage

/* rtl/cme_req_if.sv */
`timescale 1ns / 1ps

interface cme_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] char_code;
   logic       final_char;

   modport source (output valid, output char_code, output final_char, input ready);
   modport sink   (input valid, input char_code, input final_char, output ready);
endinterface

/* rtl/cme_rsp_if.sv */
`timescale 1ns / 1ps

interface cme_rsp_if;
   logic        valid;
   logic        ready;
   logic [12:0] pattern_bits;
   logic [3:0]  pattern_width;
   logic        run_last;
   logic        code_end;

   modport source (output valid, output pattern_bits, output pattern_width,
                   output run_last, output code_end, input ready);
   modport sink   (input valid, input pattern_bits, input pattern_width,
                   input run_last, input code_end, output ready);
endinterface

/* rtl/codabar_module_encoder.sv */
`timescale 1ns / 1ps
// the first chunk of a request passes through the request queue and then the output register to rsp
// the emitter sends one chunk per cycle while rsp is not stalled; a request has 0 to 7 chunks,
// picked in order by the chunk-select logic behind the request queue
// a four-deep queue lets requests be accepted while the emitter is busy
// reset (synchronous, active high) empties the queue and drops any pending chunk

module codabar_module_encoder import cme_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   cme_req_if.sink   req_bus,
   cme_rsp_if.source rsp_bus
);

   qport_type push;
   qport_type head;
   logic      q_full;
   logic      pop;

   cme_front u_front (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .q_full  (q_full),
      .push    (push)
   );

   cme_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .full  (q_full),
      .head  (head),
      .pop   (pop)
   );

   cme_back u_back (
      .clock   (clock),
      .reset   (reset),
      .head    (head),
      .pop     (pop),
      .rsp_bus (rsp_bus)
   );

endmodule

/* rtl/cme_front.sv */
`timescale 1ns / 1ps

module cme_front import cme_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   cme_req_if.sink   req_bus,
   input  logic      q_full,
   output qport_type push
);

   logic       started_ff, started_in;
   logic [7:0] c;
   logic       is_letter;
   logic       data_ok;
   logic [3:0] data_idx;
   logic       accept;

   assign c         = req_bus.char_code;
   assign is_letter = (c >= 8'h41) && (c <= 8'h44);
   assign req_bus.ready = !q_full;
   assign accept    = req_bus.valid && !q_full;

   always_comb begin
      data_ok  = 1'b1;
      data_idx = 4'd0;
      if (c >= 8'h30 && c <= 8'h39) begin
         data_idx = 4'(c - 8'h30);
      end else begin
         case (c)
            8'h2D:   data_idx = 4'd10;  // -
            8'h24:   data_idx = 4'd11;  // $
            8'h2E:   data_idx = 4'd12;  // .
            8'h2F:   data_idx = 4'd13;  // /
            8'h3A:   data_idx = 4'd14;  // :
            8'h2B:   data_idx = 4'd15;  // +
            default: data_ok  = 1'b0;
         endcase
      end
   end

   // a letter serves as start when first and as stop when final
   always_comb begin
      push.valid         = accept;
      push.plan.do_start = !started_ff;
      push.plan.do_data  = data_ok;
      push.plan.do_end   = req_bus.final_char;
      push.plan.edge_idx = is_letter ? {3'b100, 2'(c[1:0] - 2'd1)} : SymA;
      push.plan.data_idx = data_idx;
   end

   always_comb begin
      started_in = started_ff;
      if (accept) begin
         started_in = !req_bus.final_char;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         started_ff <= 1'b0;
      end else begin
         started_ff <= started_in;
      end
   end

endmodule

/* rtl/cme_queue.sv */
`timescale 1ns / 1ps

module cme_queue import cme_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  qport_type push,
   output logic      full,
   output qport_type head,
   input  logic      pop
);

   plan_type             mem [QueueDepth];
   logic [QueuePtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QueuePtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QueueCntW-1:0] count_ff, count_in;
   logic                 do_push;
   logic                 do_pop;

   assign full       = (count_ff == QueueCntW'(QueueDepth));
   assign do_push    = push.valid && !full;
   assign do_pop     = pop && (count_ff != '0);
   assign head.valid = (count_ff != '0);
   assign head.plan  = mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QueuePtrW'(QueueDepth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QueuePtrW'(QueueDepth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[wr_ptr_ff] <= push.plan;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

`ifndef SYNTHESIS
   a_pop_needs_entry: assert property (@(posedge clock) disable iff (reset)
      pop |-> count_ff != '0)
      else $error("queue popped while empty");

   a_count_tracks: assert property (@(posedge clock) disable iff (reset)
      (do_push && !do_pop) |=> count_ff == $past(count_ff) + 1'b1)
      else $error("queue count lost a request");
`endif

endmodule

/* rtl/cme_back.sv */
`timescale 1ns / 1ps

module cme_back import cme_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  qport_type head,
   output logic      pop,
   cme_rsp_if.source rsp_bus
);

   logic [NumSlots-1:0] done_ff, done_in;
   logic [NumSlots-1:0] mask;
   logic [NumSlots-1:0] rem;
   logic [NumSlots-1:0] sel;
   logic [NumSlots-1:0] rest;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [12:0] bits_ff, bits_in;
   logic [3:0]  width_ff, width_in;
   logic        last_ff, last_in;
   logic        end_ff, end_in;

   logic        out_free;
   logic        emit;
   logic [12:0] ch_bits;
   logic [3:0]  ch_width;
   logic        ch_end;

   always_comb begin
      mask = '0;
      mask[SLOT_LEAD_QUIET] = head.plan.do_start;
      mask[SLOT_START_SYM]  = head.plan.do_start;
      mask[SLOT_START_GAP]  = head.plan.do_start;
      mask[SLOT_DATA_SYM]   = head.plan.do_data;
      mask[SLOT_DATA_GAP]   = head.plan.do_data;
      mask[SLOT_STOP_SYM]   = head.plan.do_end;
      mask[SLOT_END_QUIET]  = head.plan.do_end;
   end

   // lowest slot still owed for the request at the head
   assign rem  = mask & ~done_ff;
   assign sel  = rem & (~rem + 1'b1);
   assign rest = rem & ~sel;

   assign out_free = !rsp_valid_ff || rsp_bus.ready;
   assign emit     = head.valid && (rem != '0) && out_free;
   // a request with nothing to send leaves at once
   assign pop      = head.valid && ((rem == '0) || (out_free && (rest == '0)));

   always_comb begin
      ch_bits  = '0;
      ch_width = GapWidth;
      ch_end   = 1'b0;
      if (sel[SLOT_LEAD_QUIET]) begin
         ch_width = QuietWidth;
      end else if (sel[SLOT_START_SYM] || sel[SLOT_STOP_SYM]) begin
         ch_bits  = sym_bits(head.plan.edge_idx);
         ch_width = sym_width(head.plan.edge_idx);
      end else if (sel[SLOT_DATA_SYM]) begin
         ch_bits  = sym_bits({1'b0, head.plan.data_idx});
         ch_width = sym_width({1'b0, head.plan.data_idx});
      end else if (sel[SLOT_END_QUIET]) begin
         ch_width = QuietWidth;
         ch_end   = 1'b1;
      end
   end

   always_comb begin
      done_in      = done_ff;
      rsp_valid_in = rsp_valid_ff;
      bits_in      = bits_ff;
      width_in     = width_ff;
      last_in      = last_ff;
      end_in       = end_ff;
      if (pop) begin
         done_in = '0;
      end else if (emit) begin
         done_in = done_ff | sel;
      end
      if (out_free) begin
         rsp_valid_in = emit;
         bits_in      = ch_bits;
         width_in     = ch_width;
         last_in      = (rest == '0);
         end_in       = ch_end;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         done_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         done_ff      <= done_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      bits_ff  <= bits_in;
      width_ff <= width_in;
      last_ff  <= last_in;
      end_ff   <= end_in;
   end

   assign rsp_bus.valid         = rsp_valid_ff;
   assign rsp_bus.pattern_bits  = bits_ff;
   assign rsp_bus.pattern_width = width_ff;
   assign rsp_bus.run_last      = last_ff;
   assign rsp_bus.code_end      = end_ff;

`ifndef SYNTHESIS
   a_end_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && end_ff |-> last_ff)
      else $error("closing quiet zone not marked last");

   a_pop_clears: assert property (@(posedge clock) disable iff (reset)
      pop |=> done_ff == '0)
      else $error("slot mask not cleared after pop");
`endif

endmodule

/* tb/sv/tb_codabar_module_encoder.sv */
`timescale 1ns / 1ps

module tb_codabar_module_encoder;
   import cme_pkg::*;

   localparam int CycleLimit  = 400000;
   localparam int MaxReports  = 10;
   localparam int DrainCycles = 20;
   localparam int HoldCycles  = 300;

   typedef struct packed {
      logic [12:0] bits;
      logic [3:0]  width;
      logic        run_last;
      logic        code_end;
   } chunk_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   cme_req_if req_if ();
   cme_rsp_if rsp_if ();

   codabar_module_encoder u_top (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_if),
      .rsp_bus (rsp_if)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // bar patterns: digits, then - $ . / : +, then the letters A to D
   logic [12:0] bar_patterns [0:19] = '{
      13'h0547, 13'h0571, 13'h0517, 13'h0715, 13'h05D1, 13'h0751, 13'h0457, 13'h045D,
      13'h0475, 13'h0745, 13'h051D, 13'h05C5, 13'h1DDD, 13'h1DD7, 13'h1D77, 13'h1777,
      13'h1711, 13'h1117, 13'h1447, 13'h1471
   };
   string data_chars = "0123456789-$./:+";

   logic      code_open = 1'b0;
   chunk_type expected_chunks [$];
   int        mismatches    = 0;
   int        send_idle_pct = 0;
   int        rsp_stall_pct = 0;
   int        hold_left     = 0;
   int        items_sent    = 0;
   int        cycle_count   = 0;

   function automatic logic is_letter(input logic [7:0] c);
      return c >= "A" && c <= "D";
   endfunction

   function automatic int data_symbol(input logic [7:0] c);
      if (c >= "0" && c <= "9") return int'(c - "0");
      case (c)
         "-":     return 10;
         "$":     return 11;
         ".":     return 12;
         "/":     return 13;
         ":":     return 14;
         "+":     return 15;
         default: return -1;
      endcase
   endfunction

   function automatic chunk_type make_chunk(input logic [12:0] bits, input logic [3:0] width,
                                            input logic code_end);
      chunk_type ch;
      ch.bits     = bits;
      ch.width    = width;
      ch.run_last = 1'b0;
      ch.code_end = code_end;
      return ch;
   endfunction

   function automatic chunk_type symbol_chunk(input logic [4:0] idx);
      return make_chunk(bar_patterns[idx], (idx >= 5'd12) ? 4'd13 : 4'd11, 1'b0);
   endfunction

   task automatic predict_chunks(input logic [7:0] c, input logic fin);
      chunk_type  run [$];
      logic [4:0] stop_sym;
      logic       taken;
      int         d;
      stop_sym = SymA;
      taken    = 1'b0;
      if (!code_open) begin
         run.push_back(make_chunk(13'd0, QuietWidth, 1'b0));
         if (is_letter(c)) begin
            // a leading letter is both the start and the default stop
            stop_sym = SymA + 5'(c - "A");
            taken    = 1'b1;
         end
         run.push_back(symbol_chunk(stop_sym));
         run.push_back(make_chunk(13'd0, GapWidth, 1'b0));
         code_open = 1'b1;
      end
      if (!taken) begin
         if (fin && is_letter(c)) begin
            stop_sym = SymA + 5'(c - "A");
         end else begin
            d = data_symbol(c);
            if (d >= 0) begin
               run.push_back(symbol_chunk(5'(d)));
               run.push_back(make_chunk(13'd0, GapWidth, 1'b0));
            end
         end
      end
      if (fin) begin
         run.push_back(symbol_chunk(stop_sym));
         run.push_back(make_chunk(13'd0, QuietWidth, 1'b1));
         code_open = 1'b0;
      end
      if (run.size() > 0) run[run.size() - 1].run_last = 1'b1;
      foreach (run[i]) expected_chunks.push_back(run[i]);
   endtask

   function automatic void note_mismatch(input string what, input chunk_type want,
                                         input chunk_type got);
      mismatches++;
      if (mismatches <= MaxReports) begin
         $display("%s: expected bits %h width %0d last %b end %b, got bits %h width %0d last %b end %b",
                  what, want.bits, want.width, want.run_last, want.code_end,
                  got.bits, got.width, got.run_last, got.code_end);
      end
   endfunction

   // requests are predicted before chunks are checked, in one process
   always @(posedge clock) begin
      chunk_type got;
      chunk_type want;
      if (!reset) begin
         if (req_if.valid && req_if.ready) predict_chunks(req_if.char_code, req_if.final_char);
         if (rsp_if.valid && rsp_if.ready) begin
            got.bits     = rsp_if.pattern_bits;
            got.width    = rsp_if.pattern_width;
            got.run_last = rsp_if.run_last;
            got.code_end = rsp_if.code_end;
            if (expected_chunks.size() == 0) begin
               note_mismatch("unexpected chunk", '0, got);
            end else begin
               want = expected_chunks.pop_front();
               if (got.bits !== want.bits || got.width !== want.width ||
                   got.run_last !== want.run_last || got.code_end !== want.code_end)
                  note_mismatch("chunk mismatch", want, got);
            end
         end
      end
   end

   // receiver: random stalls, or a long hold-off counted down here
   always @(negedge clock) begin
      if (hold_left > 0) begin
         rsp_if.ready = 1'b0;
         hold_left--;
      end else begin
         rsp_if.ready = ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   task automatic send_char(input logic [7:0] c, input logic fin);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_if.valid = 1'b0;
         @(negedge clock);
      end
      req_if.char_code  = c;
      req_if.final_char = fin;
      req_if.valid      = 1'b1;
      do @(posedge clock); while (!req_if.ready);
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) send_char(s[i], i == s.len() - 1);
   endtask

   function automatic logic [7:0] pick_char(input logic first, input logic last);
      int roll;
      roll = $urandom_range(99);
      if (roll < 6) return 8'($urandom_range(255));
      if (roll < 12 || ((first || last) && roll < 55)) return "A" + 8'($urandom_range(3));
      return data_chars[$urandom_range(15)];
   endfunction

   task automatic send_random_string();
      int         len;
      logic [7:0] c;
      logic       fin;
      len = ($urandom_range(9) == 0) ? $urandom_range(30, 13) : $urandom_range(12, 1);
      for (int i = 0; i < len; i++) begin
         fin = (i == len - 1);
         c   = pick_char(i == 0, fin);
         send_char(c, fin);
         items_sent++;
      end
   endtask

   task automatic run_random_strings(input int n_items);
      int target;
      target = items_sent + n_items;
      while (items_sent < target) send_random_string();
   endtask

   task automatic test_directed_strings();
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      send_text("A");
      send_text("B");
      send_text("C0123456789D");
      send_text("$-./:+");
      // unknown characters, a letter in mid string, and an unknown final
      send_char("X", 1'b0);
      send_char(8'h00, 1'b0);
      send_char("B", 1'b0);
      send_char(8'hFF, 1'b1);
      send_text("D");
   endtask

   task automatic test_free_flowing();
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      run_random_strings(90);
   endtask

   task automatic test_sender_gaps();
      send_idle_pct = 80;
      rsp_stall_pct = 0;
      run_random_strings(70);
   endtask

   task automatic test_receiver_stalls();
      send_idle_pct = 0;
      rsp_stall_pct = 80;
      run_random_strings(70);
   endtask

   task automatic test_both_idle();
      send_idle_pct = 20;
      rsp_stall_pct = 20;
      run_random_strings(70);
   endtask

   task automatic test_long_backpressure();
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      hold_left     = HoldCycles;
      run_random_strings(50);
   endtask

   initial begin
      while (cycle_count < CycleLimit) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("FAIL codabar_module_encoder");
      $finish;
   end

   initial begin
      req_if.valid      = 1'b0;
      req_if.char_code  = 8'h00;
      req_if.final_char = 1'b0;
      rsp_if.ready      = 1'b0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_directed_strings();
      test_free_flowing();
      test_sender_gaps();
      test_receiver_stalls();
      test_both_idle();
      test_long_backpressure();

      @(negedge clock);
      req_if.valid  = 1'b0;
      rsp_stall_pct = 0;
      while (expected_chunks.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
      if (expected_chunks.size() != 0) begin
         mismatches += expected_chunks.size();
         $display("%0d expected chunks never arrived", expected_chunks.size());
      end

      if (mismatches == 0) begin
         $display("PASS codabar_module_encoder");
      end else begin
         $display("FAIL codabar_module_encoder");
      end
      $finish;
   end

endmodule
